// ===== sv/frq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frq_pkg;

    localparam int ENTRIES   = 1024;
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 64;
    localparam int TOP_SLOT  = ENTRIES + 1;
    localparam int SLOTS     = ENTRIES + 2;
    localparam int SLOT_W    = $clog2(SLOTS);
    // one extra bit so the upward walk can step past the top slot
    localparam int POS_W     = SLOT_W + 1;

    localparam logic [IDX_W:0] ENTRY_LIMIT = (IDX_W + 1)'(ENTRIES);
    localparam logic [POS_W-1:0] TOP_POS   = POS_W'(TOP_SLOT);

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [DATA_W-1:0] slope;
        logic [DATA_W-1:0] offset;
    } node_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
        node_t data;
    } wr_req_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
    } rd_req_t;

endpackage

`default_nettype wire

// ===== sv/frq_node_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Node memory for both trees, one {slope, offset} word per slot.
// Sweeps every slot to zero after reset; busy stays high meanwhile.
module frq_node_store (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire frq_pkg::rd_req_t rd,
    output frq_pkg::node_t       rd_data,
    input  wire frq_pkg::wr_req_t wr,
    output logic                 busy
);

    frq_pkg::node_t mem [frq_pkg::SLOTS];

    frq_pkg::slot_t clr_cnt_reg;
    frq_pkg::slot_t clr_cnt_next;
    logic           clr_busy_reg;
    logic           clr_busy_next;
    frq_pkg::node_t rd_data_reg;

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            if (clr_cnt_reg == frq_pkg::slot_t'(frq_pkg::SLOTS - 1)) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// ===== sv/fenwick_range_update_range_query.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A set runs as a one-entry query, then an add; a rejected request goes straight to S_DONE.
// Each tree node is a read state (S_QRD or S_URD), then S_QACC or S_UWR.
// One transaction at a time: the next is taken the cycle after the result is loaded at the
// earliest; a result waiting on m_ready holds the sequencer.
// Reset: synchronous active-low aresetn; then the node memory is swept to zero.

module fenwick_range_update_range_query (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_req_type,
    input  wire logic [frq_pkg::IDX_W-1:0]   s_start_index,
    input  wire logic [frq_pkg::IDX_W-1:0]   s_end_index,
    input  wire logic signed [31:0]          s_operand_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [frq_pkg::DATA_W-1:0] m_range_total,
    output logic                             m_status
);

    localparam int DW = frq_pkg::DATA_W;
    localparam int PW = frq_pkg::POS_W;
    localparam int IW = frq_pkg::IDX_W;

    // Sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_QRD   = 4'd1;   // issue read of a prefix node
    localparam logic [3:0] S_QACC  = 4'd2;   // accumulate both trees, step down
    localparam logic [3:0] S_QMUL  = 4'd3;   // slope prefix times position
    localparam logic [3:0] S_QFIN  = 4'd4;   // prefix total = product - offset prefix
    localparam logic [3:0] S_QEND  = 4'd5;   // store first prefix or form range sum
    localparam logic [3:0] S_SETD  = 4'd6;   // set: delta = new value - old value
    localparam logic [3:0] S_UMUL  = 4'd7;   // offset increment product
    localparam logic [3:0] S_UPREP = 4'd8;   // sign of offset increment
    localparam logic [3:0] S_URD   = 4'd9;   // issue read of an update node
    localparam logic [3:0] S_UWR   = 4'd10;  // write node back, step up
    localparam logic [3:0] S_DONE  = 4'd11;  // hand result to output register

    logic [3:0]     state_reg, state_next;
    logic [1:0]     kind_reg, kind_next;
    logic [IW-1:0]  lo_reg, lo_next;
    logic [IW-1:0]  hi_reg, hi_next;
    logic [DW-1:0]  val_reg, val_next;
    logic           pass_reg, pass_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [PW-1:0]  ppos_reg, ppos_next;
    logic [DW-1:0]  acc_s_reg, acc_s_next;
    logic [DW-1:0]  acc_o_reg, acc_o_next;
    logic [DW-1:0]  first_reg, first_next;
    logic [DW-1:0]  delta_reg, delta_next;
    logic [DW-1:0]  wr_s_reg, wr_s_next;
    logic [DW-1:0]  wr_o_reg, wr_o_next;
    logic [DW-1:0]  mul_reg, mul_next;
    logic [DW-1:0]  res_total_reg, res_total_next;
    logic           res_status_reg, res_status_next;
    logic           out_valid_reg, out_valid_next;
    logic [DW-1:0]  out_total_reg, out_total_next;
    logic           out_status_reg, out_status_next;

    frq_pkg::rd_req_t rd;
    frq_pkg::wr_req_t wr;
    frq_pkg::node_t   rd_data;
    logic             store_busy;

    frq_node_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rd),
        .rd_data (rd_data),
        .wr      (wr),
        .busy    (store_busy)
    );

    // Shared multiplier operands; product is registered in mul_reg
    logic [DW-1:0]  mul_a;
    logic [PW-1:0]  mul_b;
    logic [PW-1:0]  low_bit;
    logic [PW-1:0]  hi_plus1;
    logic           in_accept;
    logic           bad_range;
    logic           bad_set;
    logic [DW-1:0]  op_sext;
    logic           out_free;

    assign s_ready   = (state_reg == S_IDLE) && !store_busy;
    assign in_accept = s_valid && s_ready;
    assign op_sext   = {{(DW - 32){s_operand_value[31]}}, s_operand_value};
    assign bad_range = (s_start_index > s_end_index) ||
                       ({1'b0, s_end_index} >= frq_pkg::ENTRY_LIMIT);
    assign bad_set   = ({1'b0, s_start_index} >= frq_pkg::ENTRY_LIMIT);
    assign low_bit   = pos_reg & (~pos_reg + 1'b1);
    assign hi_plus1  = PW'(hi_reg) + 1'b1;
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        val_next        = val_reg;
        pass_next       = pass_reg;
        pos_next        = pos_reg;
        ppos_next       = ppos_reg;
        acc_s_next      = acc_s_reg;
        acc_o_next      = acc_o_reg;
        first_next      = first_reg;
        delta_next      = delta_reg;
        wr_s_next       = wr_s_reg;
        wr_o_next       = wr_o_reg;
        mul_next        = mul_reg;
        res_total_next  = res_total_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_total_next  = out_total_reg;
        out_status_next = out_status_reg;

        rd.en   = 1'b0;
        rd.addr = pos_reg[frq_pkg::SLOT_W-1:0];
        wr.en   = 1'b0;
        wr.addr = pos_reg[frq_pkg::SLOT_W-1:0];
        wr.data.slope  = rd_data.slope + wr_s_reg;
        wr.data.offset = rd_data.offset + wr_o_reg;

        mul_a = delta_reg;
        mul_b = pass_reg ? hi_plus1 : PW'(lo_reg);

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    kind_next  = s_req_type;
                    lo_next    = s_start_index;
                    hi_next    = (s_req_type == frq_pkg::REQ_SET) ? s_start_index
                                                                  : s_end_index;
                    val_next   = op_sext;
                    delta_next = op_sext;
                    pass_next  = 1'b0;
                    acc_s_next = '0;
                    acc_o_next = '0;
                    res_total_next  = '0;
                    res_status_next = 1'b1;
                    case (s_req_type)
                        frq_pkg::REQ_ADD: begin
                            state_next = bad_range ? S_DONE : S_UMUL;
                        end
                        frq_pkg::REQ_SET: begin
                            pos_next   = PW'(s_start_index) + 1'b1;
                            ppos_next  = PW'(s_start_index) + 1'b1;
                            state_next = bad_set ? S_DONE : S_QRD;
                        end
                        frq_pkg::REQ_QUERY: begin
                            pos_next   = PW'(s_end_index) + 1'b1;
                            ppos_next  = PW'(s_end_index) + 1'b1;
                            state_next = bad_range ? S_DONE : S_QRD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_QRD: begin
                if (pos_reg == '0) begin
                    state_next = S_QMUL;
                end else begin
                    rd.en      = 1'b1;
                    state_next = S_QACC;
                end
            end
            S_QACC: begin
                acc_s_next = acc_s_reg + rd_data.slope;
                acc_o_next = acc_o_reg + rd_data.offset;
                pos_next   = pos_reg & (pos_reg - 1'b1);
                state_next = S_QRD;
            end
            S_QMUL: begin
                mul_a      = acc_s_reg;
                mul_b      = ppos_reg;
                mul_next   = DW'(mul_a * DW'(mul_b));
                state_next = S_QFIN;
            end
            S_QFIN: begin
                acc_o_next = mul_reg - acc_o_reg;
                state_next = S_QEND;
            end
            S_QEND: begin
                if (!pass_reg) begin
                    first_next = acc_o_reg;
                    pass_next  = 1'b1;
                    pos_next   = PW'(lo_reg);
                    ppos_next  = PW'(lo_reg);
                    acc_s_next = '0;
                    acc_o_next = '0;
                    state_next = S_QRD;
                end else begin
                    first_next = first_reg - acc_o_reg;
                    if (kind_reg == frq_pkg::REQ_QUERY) begin
                        res_total_next  = first_reg - acc_o_reg;
                        res_status_next = 1'b0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_SETD;
                    end
                end
            end
            S_SETD: begin
                delta_next = val_reg - first_reg;
                pass_next  = 1'b0;
                state_next = S_UMUL;
            end
            S_UMUL: begin
                // pass 0 at lo+1 with (d, d*lo); pass 1 at hi+2 with (-d, -d*(hi+1))
                mul_next   = DW'(mul_a * DW'(mul_b));
                wr_s_next  = pass_reg ? (DW'(0) - delta_reg) : delta_reg;
                pos_next   = pass_reg ? (hi_plus1 + 1'b1) : (PW'(lo_reg) + 1'b1);
                state_next = S_UPREP;
            end
            S_UPREP: begin
                wr_o_next  = pass_reg ? (DW'(0) - mul_reg) : mul_reg;
                state_next = S_URD;
            end
            S_URD: begin
                if (pos_reg > frq_pkg::TOP_POS) begin
                    if (!pass_reg) begin
                        pass_next  = 1'b1;
                        state_next = S_UMUL;
                    end else begin
                        res_total_next  = '0;
                        res_status_next = 1'b0;
                        state_next      = S_DONE;
                    end
                end else begin
                    rd.en      = 1'b1;
                    state_next = S_UWR;
                end
            end
            S_UWR: begin
                wr.en      = 1'b1;
                pos_next   = pos_reg + low_bit;
                state_next = S_URD;
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_total_next  = res_total_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        val_reg        <= val_next;
        pass_reg       <= pass_next;
        pos_reg        <= pos_next;
        ppos_reg       <= ppos_next;
        acc_s_reg      <= acc_s_next;
        acc_o_reg      <= acc_o_next;
        first_reg      <= first_next;
        delta_reg      <= delta_next;
        wr_s_reg       <= wr_s_next;
        wr_o_reg       <= wr_o_next;
        mul_reg        <= mul_next;
        res_total_reg  <= res_total_next;
        res_status_reg <= res_status_next;
        out_total_reg  <= out_total_next;
        out_status_reg <= out_status_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_range_total = out_total_reg;
    assign m_status      = out_status_reg;

endmodule

`default_nettype wire

// ===== sim/frq_sum_checker.sv =====
`timescale 1ns / 1ps

module frq_sum_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [1:0]                       s_req_type,
    input  logic [frq_pkg::IDX_W-1:0]        s_start_index,
    input  logic [frq_pkg::IDX_W-1:0]        s_end_index,
    input  logic signed [31:0]               s_operand_value,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic signed [frq_pkg::DATA_W-1:0] m_range_total,
    input  logic                             m_status,
    output int                               mismatch_count,
    output int                               outstanding
);
    import frq_pkg::*;

    typedef struct packed {
        int                seq;
        logic [DATA_W-1:0] total;
        logic              rejected;
    } outcome_t;

    // Both trees are linear mod 2^64, so a flat array of entries gives the same sums.
    logic [DATA_W-1:0] entry_value [ENTRIES];
    outcome_t          pending_outcomes [$];
    int                request_seq;

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic outcome_t predict_request(logic [1:0] kind, int lo, int hi,
                                                 logic signed [31:0] operand);
        outcome_t          res;
        logic [DATA_W-1:0] delta;
        logic [DATA_W-1:0] acc;
        res   = '0;
        acc   = '0;
        delta = {{(DATA_W - 32){operand[31]}}, operand};
        case (kind)
            REQ_ADD: begin
                if (lo > hi || hi >= ENTRIES) begin
                    res.rejected = 1'b1;
                end else begin
                    for (int i = lo; i <= hi; i++) entry_value[i] += delta;
                end
            end
            REQ_SET: begin
                if (lo >= ENTRIES) res.rejected = 1'b1;
                else entry_value[lo] = delta;
            end
            REQ_QUERY: begin
                if (lo > hi || hi >= ENTRIES) begin
                    res.rejected = 1'b1;
                end else begin
                    for (int i = lo; i <= hi; i++) acc += entry_value[i];
                    res.total = acc;
                end
            end
            default: res.rejected = 1'b1;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            foreach (entry_value[i]) entry_value[i] = '0;
            pending_outcomes.delete();
            request_seq = 0;
        end else begin
            if (s_valid && s_ready) begin
                want     = predict_request(s_req_type, s_start_index, s_end_index,
                                           s_operand_value);
                want.seq = request_seq++;
                pending_outcomes.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, total %0d rejected %0b",
                                              m_range_total, m_status));
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_range_total !== want.total)
                        report_mismatch($sformatf("request %0d: total %0d, want %0d",
                                                  want.seq, m_range_total,
                                                  $signed(want.total)));
                    if (m_status !== want.rejected)
                        report_mismatch($sformatf("request %0d: rejected %0b, want %0b",
                                                  want.seq, m_status, want.rejected));
                end
            end
        end
        outstanding <= pending_outcomes.size();
    end

endmodule

// ===== sim/fenwick_range_update_range_query_tb.sv =====
`timescale 1ns / 1ps

module fenwick_range_update_range_query_tb;
    import frq_pkg::*;

    // Request code the block does not define; must come back rejected.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int RANDOM_REQUESTS = 950;
    // Slowest legal run: ~1000 sets, plus long stalls and gaps, plus the sweep of
    // the node memory after reset. This is several times that.
    localparam int CYCLE_LIMIT     = 1_000_000;
    // A set is the slowest request.
    localparam int DRAIN_CYCLES    = 150;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_e;

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_req_type      = REQ_QUERY;
    logic [IDX_W-1:0]          s_start_index   = '0;
    logic [IDX_W-1:0]          s_end_index     = '0;
    logic signed [31:0]        s_operand_value = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic signed [DATA_W-1:0]  m_range_total;
    logic                      m_status;

    int          mismatch_count;
    int          outstanding;
    int          cycle_count;
    int          burst_left;
    ready_mode_e ready_mode = READY_ALWAYS;
    int          ready_left;

    always #(CLK_HALF) aclk = ~aclk;

    fenwick_range_update_range_query i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_start_index   (s_start_index),
        .s_end_index     (s_end_index),
        .s_operand_value (s_operand_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_range_total   (m_range_total),
        .m_status        (m_status)
    );

    // Watches both channels, keeps its own copy of the array, counts mismatches.
    frq_sum_checker i_sum_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_start_index   (s_start_index),
        .s_end_index     (s_end_index),
        .s_operand_value (s_operand_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_range_total   (m_range_total),
        .m_status        (m_status),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result-side back-pressure. The mode holds for a random stretch, so there are
    // long runs with no stall at all as well as heavy stalling.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            ready_left <= $urandom_range(16, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE:   m_ready <= ($urandom_range(0, 7) == 0);
            default:        m_ready <= (ready_left[2:0] != 3'd0);
        endcase
    end

    // Drives one transaction and returns at the edge where it is taken. Between
    // bursts valid drops for a random gap; gaps reach past one whole request,
    // so they fall on every phase of the tree walk.
    task automatic send_request(logic [1:0] kind, int lo, int hi,
                                logic signed [31:0] operand);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                5, 6, 7:       gap = $urandom_range(1, 6);
                default:       gap = $urandom_range(7, 120);
            endcase
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_req_type      <= kind;
        s_start_index   <= IDX_W'(lo);
        s_end_index     <= IDX_W'(hi);
        s_operand_value <= operand;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Indexes lean toward the ends of the array and toward powers of two, where
    // the tree walks change length.
    function automatic int pick_index();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 3);
        if (sel == 1) return ENTRIES - 1 - $urandom_range(0, 3);
        if (sel == 2) return (1 << $urandom_range(0, IDX_W - 1)) - $urandom_range(0, 1);
        return $urandom_range(0, ENTRIES - 1);
    endfunction

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 19))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4, 5, 6: return $signed(32'($urandom_range(0, 200))) - 32'sd100;
            default: return $signed($urandom());
        endcase
    endfunction

    initial begin
        int lo;
        int hi;
        int swap;
        int roll;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty array, extreme operands, both array ends, the 511/512
        // boundary, overwrite by set, reversed ranges and the unused request code.
        send_request(REQ_QUERY,  0,    ENTRIES - 1, 32'sd0);
        send_request(REQ_ADD,    0,    ENTRIES - 1, 32'sh7fffffff);
        send_request(REQ_ADD,    ENTRIES - 1, ENTRIES - 1, 32'sh80000000);
        send_request(REQ_ADD,    0,    0,           -32'sd1);
        send_request(REQ_ADD,    511,  512,         32'sd12345);
        send_request(REQ_SET,    0,    ENTRIES - 1, 32'sh80000000);
        send_request(REQ_SET,    ENTRIES - 1, 0,    32'sh7fffffff);
        send_request(REQ_SET,    512,  5,           32'sd0);
        send_request(REQ_QUERY,  0,    0,           32'sh7fffffff);
        send_request(REQ_QUERY,  ENTRIES - 1, ENTRIES - 1, 32'sh80000000);
        send_request(REQ_QUERY,  511,  512,         32'sd0);
        send_request(REQ_QUERY,  0,    ENTRIES - 1, 32'sd0);
        send_request(REQ_QUERY,  1,    ENTRIES - 2, 32'sd0);
        send_request(REQ_ADD,    10,   9,           32'sd77);
        send_request(REQ_QUERY,  ENTRIES - 1, 0,    32'sd0);
        send_request(REQ_UNUSED, 0,    ENTRIES - 1, -32'sd1);
        send_request(REQ_UNUSED, ENTRIES - 1, 0,    32'sh7fffffff);
        send_request(REQ_SET,    5,    5,           32'sd100);
        send_request(REQ_SET,    5,    900,         -32'sd100);
        send_request(REQ_QUERY,  5,    5,           32'sd0);
        send_request(REQ_QUERY,  0,    ENTRIES - 1, 32'sd0);

        // Random: mostly well-formed adds, sets and queries, some rejects.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            roll = $urandom_range(0, 99);
            lo   = pick_index();
            hi   = pick_index();
            if ($urandom_range(0, 7) == 0) hi = lo;
            if (roll < 90) begin
                if (lo > hi) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                if (roll < 35) send_request(REQ_ADD, lo, hi, pick_operand());
                else if (roll < 55) send_request(REQ_SET, lo, pick_index(), pick_operand());
                else send_request(REQ_QUERY, lo, hi, pick_operand());
            end else if (roll < 97) begin
                // reversed range, start strictly after end
                if (lo == hi) begin
                    if (lo < ENTRIES - 1) lo++;
                    else hi--;
                end
                if (lo < hi) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                send_request(roll[0] ? REQ_ADD : REQ_QUERY, lo, hi, pick_operand());
            end else begin
                send_request(REQ_UNUSED, lo, hi, pick_operand());
            end
        end
        s_valid <= 1'b0;

        // Let the checker see the last acceptance, then drain.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
